/* hdl/spmnb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scale pitch to MIDI note package
// Shared widths, register codes and the sideband type that travels with an
// item through the divider.
// ----------------------------------------------------------------------------
package spmnb_pkg;

    // Tuning table geometry
    localparam int MAX_DEGREES = 64;
    localparam int DEG_AW      = $clog2(MAX_DEGREES);
    localparam int SIZE_W      = 7;

    // Input field widths
    localparam int PITCH_W = 16;
    localparam int DIDX_W  = 7;
    localparam int OCT_W   = 20;

    // Arithmetic widths: Q.16 positions in octaves and semitones
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = PITCH_W + OCT_W;
    localparam int POS_W   = PROD_W + 1;
    localparam int SEMI_W  = POS_W + 4;
    localparam int RND_W   = SEMI_W + 1;

    localparam logic [3:0]        SEMIS_PER_OCTAVE = 4'd12;
    localparam logic [FRAC_W-1:0] ROUND_HALF       = 16'h8000;

    // Output fields
    localparam int NOTE_COUNT  = 128;
    localparam int NOTE_W      = 7;
    localparam int BEND_SHIFT  = 4;
    localparam int BEND_W      = FRAC_W - BEND_SHIFT;

    // Stream data widths, padded to whole bytes
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;

    // Divider: restoring steps per stage, one quotient bit per step
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = PITCH_W / DIV_STEPS;

    // Request kinds carried on tuser
    localparam logic MODE_CONVERT = 1'b0;
    localparam logic MODE_LOAD    = 1'b1;

    // Configuration registers
    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_SCALE_SIZE   = 1'b0;
    localparam logic [SIZE_W-1:0]    SCALE_SIZE_RESET = 7'd12;

    // Sideband that follows a request through the divider
    typedef struct packed {
        logic              conv;
        logic              we;
        logic [DEG_AW-1:0] waddr;
        logic [OCT_W-1:0]  wdata;
    } spmnb_side_t;

endpackage

/* hdl/spmnb_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered under read enable.
// ----------------------------------------------------------------------------
module spmnb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read ports, hold while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

/* hdl/spmnb_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring division of the pitch by the scale size, a few quotient bits per
// stage, with a sideband that rides along unchanged.
// ----------------------------------------------------------------------------
module spmnb_div (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [spmnb_pkg::PITCH_W-1:0]         in_dividend,
    input  logic [spmnb_pkg::SIZE_W-1:0]          in_divisor,
    input  spmnb_pkg::spmnb_side_t                in_side,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [spmnb_pkg::PITCH_W-1:0]         out_quot,
    output logic [spmnb_pkg::DEG_AW-1:0]          out_rem,
    output logic [spmnb_pkg::SIZE_W-1:0]          out_divisor,
    output spmnb_pkg::spmnb_side_t                out_side
);
    import spmnb_pkg::*;

    typedef struct packed {
        logic [DEG_AW-1:0]  r;
        logic [PITCH_W-1:0] n;
    } div_acc_t;

    logic               v_reg    [DIV_STAGES];
    logic [PITCH_W-1:0] n_reg    [DIV_STAGES];
    logic [DEG_AW-1:0]  r_reg    [DIV_STAGES];
    logic [SIZE_W-1:0]  d_reg    [DIV_STAGES];
    spmnb_side_t        side_reg [DIV_STAGES];
    logic               adv      [DIV_STAGES];

    // Run DIV_STEPS restoring steps: shift a dividend bit into the remainder,
    // subtract the divisor where it fits and shift the quotient bit in.
    function automatic div_acc_t div_steps(
        input logic [DEG_AW-1:0]  r_in,
        input logic [PITCH_W-1:0] n_in,
        input logic [SIZE_W-1:0]  d
    );
        logic [DEG_AW:0] trial;
        logic [DEG_AW:0] dd;
        div_acc_t        acc;
        dd    = (DEG_AW+1)'(d);
        acc.r = r_in;
        acc.n = n_in;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            trial = {acc.r, acc.n[PITCH_W-1]};
            acc.n = {acc.n[PITCH_W-2:0], 1'b0};
            if (trial >= dd)
            begin
                trial    = trial - dd;
                acc.n[0] = 1'b1;
            end
            acc.r = trial[DEG_AW-1:0];
        end
        return acc;
    endfunction

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_stage
        logic               src_v;
        logic [PITCH_W-1:0] src_n;
        logic [DEG_AW-1:0]  src_r;
        logic [SIZE_W-1:0]  src_d;
        spmnb_side_t        src_side;
        logic               dn_ready;
        div_acc_t           acc;

        // Select the stage source
        if (i == 0)
        begin : g_first
            assign src_v    = in_valid;
            assign src_n    = in_dividend;
            assign src_r    = '0;
            assign src_d    = in_divisor;
            assign src_side = in_side;
        end
        else
        begin : g_next
            assign src_v    = v_reg[i-1];
            assign src_n    = n_reg[i-1];
            assign src_r    = r_reg[i-1];
            assign src_d    = d_reg[i-1];
            assign src_side = side_reg[i-1];
        end

        if (i == DIV_STAGES - 1)
        begin : g_last
            assign dn_ready = out_ready;
        end
        else
        begin : g_mid
            assign dn_ready = adv[i+1];
        end

        // Advance when empty or when the next stage takes the request
        assign adv[i] = !v_reg[i] || dn_ready;
        assign acc    = div_steps(src_r, src_n, src_d);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (adv[i])
            begin
                v_reg[i] <= src_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[i] && src_v)
            begin
                n_reg[i]    <= acc.n;
                r_reg[i]    <= acc.r;
                d_reg[i]    <= src_d;
                side_reg[i] <= src_side;
            end
        end
    end

    assign in_ready    = adv[0];
    assign out_valid   = v_reg[DIV_STAGES-1];
    assign out_quot    = n_reg[DIV_STAGES-1];
    assign out_rem     = r_reg[DIV_STAGES-1];
    assign out_divisor = d_reg[DIV_STAGES-1];
    assign out_side    = side_reg[DIV_STAGES-1];

    // The remainder of a finished division is below its divisor
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (DEG_AW+1)'(out_rem) < (DEG_AW+1)'(out_divisor))
        else $error("divider remainder not below divisor");

    // A zero divisor never enters
    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> in_divisor != '0)
        else $error("zero divisor entered the divider");

endmodule

/* hdl/spmnb_tone.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Note and bend back end
// Multiplies the period count by the period, adds the degree, scales octaves
// to semitones, rounds to a note and forms the bend. Four register stages.
// ----------------------------------------------------------------------------
module spmnb_tone (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [spmnb_pkg::PITCH_W-1:0]        in_quot,
    input  logic [spmnb_pkg::OCT_W-1:0]          in_period,
    input  logic [spmnb_pkg::OCT_W-1:0]          in_degree,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 out_status,
    output logic [spmnb_pkg::NOTE_W-1:0]         out_note,
    output logic signed [spmnb_pkg::BEND_W-1:0]  out_bend
);
    import spmnb_pkg::*;

    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic               adv1, adv2, adv3, adv4;
    logic [PROD_W-1:0]  prod1_reg;
    logic [OCT_W-1:0]   deg1_reg;
    logic [POS_W-1:0]   pos2_reg;
    logic [SEMI_W-1:0]  semi3_reg;
    logic               status_reg;
    logic [NOTE_W-1:0]  note_reg;
    logic [BEND_W-1:0]  bend_reg;

    logic [PROD_W-1:0]  prod_next;
    logic [POS_W-1:0]   pos_next;
    logic [SEMI_W-1:0]  semi_next;
    logic [RND_W-1:0]   rounded;
    logic               status_next;
    logic [FRAC_W-1:0]  biased;
    logic [NOTE_W-1:0]  note_next;
    logic [BEND_W-1:0]  bend_next;

    // Stage handshake chain
    assign adv4     = !v4_reg || out_ready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    // Datapath between stages
    assign prod_next = PROD_W'(in_quot) * PROD_W'(in_period);
    assign pos_next  = POS_W'(prod1_reg) + POS_W'(deg1_reg);
    assign semi_next = SEMI_W'(pos2_reg) * SEMI_W'(SEMIS_PER_OCTAVE);

    // Round half up, range check and bend truncated toward zero
    always_comb
    begin
        rounded     = RND_W'(semi3_reg) + RND_W'(ROUND_HALF);
        status_next = rounded[RND_W-1:FRAC_W] >= (RND_W-FRAC_W)'(NOTE_COUNT);
        biased      = semi3_reg[FRAC_W-1:0];
        if (semi3_reg[FRAC_W-1])
        begin
            biased = biased + FRAC_W'((1 << BEND_SHIFT) - 1);
        end
        if (status_next)
        begin
            note_next = '0;
            bend_next = '0;
        end
        else
        begin
            note_next = rounded[FRAC_W +: NOTE_W];
            bend_next = biased[FRAC_W-1:BEND_SHIFT];
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (adv4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            prod1_reg <= prod_next;
            deg1_reg  <= in_degree;
        end
        if (adv2 && v1_reg)
        begin
            pos2_reg <= pos_next;
        end
        if (adv3 && v2_reg)
        begin
            semi3_reg <= semi_next;
        end
        if (adv4 && v3_reg)
        begin
            status_reg <= status_next;
            note_reg   <= note_next;
            bend_reg   <= bend_next;
        end
    end

    assign out_valid  = v4_reg;
    assign out_status = status_reg;
    assign out_note   = note_reg;
    assign out_bend   = signed'(bend_reg);

    // An out-of-range result carries zero note and bend
    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_status) |-> (out_note == '0 && out_bend == '0))
        else $error("out-of-range result with nonzero payload");

endmodule

/* hdl/scale_pitch_to_midi_note_bend_unit.sv */
`timescale 1ns / 1ps
// A convert request passes the input register, 4 divider stages, the table read
// and 4 back-end stages. One request per cycle while m_tready does not stall;
// the pipelined divider sets the depth.
// Reset clears all valid bits and sets scale_size to 12. The degree table is
// not cleared and reads are defined only for entries loaded since reset.
// ----------------------------------------------------------------------------
// Scale pitch to MIDI note and bend unit
// Loads a tuning table of degree positions and converts scale steps to a
// MIDI note and pitch-bend offset.
// ----------------------------------------------------------------------------
module scale_pitch_to_midi_note_bend_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // APB configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [spmnb_pkg::PADDR_W-1:0]         paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    // Request stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [15:0] pitch_index, [22:16] degree_index, [42:23] degree_octaves
    input  logic [spmnb_pkg::IN_DATA_W-1:0]       s_tdata,
    // [0] mode
    input  logic                                  s_tuser,
    // Result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [6:0] midi_note, [18:7] bend
    output logic [spmnb_pkg::OUT_DATA_W-1:0]      m_tdata,
    // [0] status
    output logic                                  m_tuser
);
    import spmnb_pkg::*;

    logic [SIZE_W-1:0]    scale_size_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;
    logic [SIZE_W-1:0]    size_clamped;

    logic [PITCH_W-1:0]   in_pitch;
    logic [DIDX_W-1:0]    in_didx;
    logic [OCT_W-1:0]     in_dval;
    spmnb_side_t          in_side;

    logic                 s0_v_reg;
    logic                 s0_adv;
    logic [PITCH_W-1:0]   s0_pitch_reg;
    logic [SIZE_W-1:0]    s0_size_reg;
    spmnb_side_t          s0_side_reg;

    logic                 div_in_ready;
    logic                 div_out_valid;
    logic                 div_out_ready;
    logic [PITCH_W-1:0]   div_out_quot;
    logic [DEG_AW-1:0]    div_out_rem;
    logic [SIZE_W-1:0]    div_out_divisor;
    spmnb_side_t          div_out_side;

    logic                 r_v_reg;
    logic                 r_adv;
    logic [PITCH_W-1:0]   r_quot_reg;
    logic                 r_rem_zero_reg;
    logic                 ram_we;
    logic [OCT_W-1:0]     ram_rdata_a;
    logic [OCT_W-1:0]     ram_rdata_b;
    logic [OCT_W-1:0]     degree_value;

    logic                 tone_in_ready;
    logic                 tone_status;
    logic [NOTE_W-1:0]    tone_note;
    logic signed [BEND_W-1:0] tone_bend;

    // Configuration register
    assign pready    = 1'b1;
    assign reg_idx   = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_size_reg <= SCALE_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_SCALE_SIZE: scale_size_reg <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SCALE_SIZE: prdata = 32'(scale_size_reg);
            default:        prdata = '0;
        endcase
    end

    // Clamp the scale size into 1..MAX_DEGREES
    always_comb
    begin
        if (scale_size_reg == '0)
        begin
            size_clamped = SIZE_W'(1);
        end
        else if (scale_size_reg > SIZE_W'(MAX_DEGREES))
        begin
            size_clamped = SIZE_W'(MAX_DEGREES);
        end
        else
        begin
            size_clamped = scale_size_reg;
        end
    end

    // Unpack the request; a load outside 1..MAX_DEGREES writes nothing
    assign in_pitch      = s_tdata[PITCH_W-1:0];
    assign in_didx       = s_tdata[PITCH_W +: DIDX_W];
    assign in_dval       = s_tdata[PITCH_W+DIDX_W +: OCT_W];
    assign in_side.conv  = (s_tuser == MODE_CONVERT);
    assign in_side.we    = (s_tuser == MODE_LOAD) && (in_didx != '0)
                           && (in_didx <= DIDX_W'(MAX_DEGREES));
    assign in_side.waddr = DEG_AW'(in_didx - DIDX_W'(1));
    assign in_side.wdata = in_dval;

    // Input register stage
    assign s0_adv   = !s0_v_reg || div_in_ready;
    assign s_tready = s0_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
        end
        else if (s0_adv)
        begin
            s0_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_adv && s_tvalid)
        begin
            s0_pitch_reg <= in_pitch;
            s0_size_reg  <= size_clamped;
            s0_side_reg  <= in_side;
        end
    end

    // Period count and degree
    spmnb_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s0_v_reg),
        .in_ready    (div_in_ready),
        .in_dividend (s0_pitch_reg),
        .in_divisor  (s0_size_reg),
        .in_side     (s0_side_reg),
        .out_valid   (div_out_valid),
        .out_ready   (div_out_ready),
        .out_quot    (div_out_quot),
        .out_rem     (div_out_rem),
        .out_divisor (div_out_divisor),
        .out_side    (div_out_side)
    );

    // Table stage: loads write here in request order and drop out,
    // converts read the period and the degree entry
    assign r_adv         = !r_v_reg || tone_in_ready;
    assign div_out_ready = r_adv;
    assign ram_we        = div_out_valid && r_adv && div_out_side.we;

    spmnb_ram #(
        .WIDTH (OCT_W),
        .DEPTH (MAX_DEGREES)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (div_out_side.waddr),
        .wdata   (div_out_side.wdata),
        .re      (r_adv),
        .raddr_a (DEG_AW'(div_out_divisor - SIZE_W'(1))),
        .raddr_b (div_out_rem - DEG_AW'(1)),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_v_reg <= 1'b0;
        end
        else if (r_adv)
        begin
            r_v_reg <= div_out_valid && div_out_side.conv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r_adv && div_out_valid)
        begin
            r_quot_reg     <= div_out_quot;
            r_rem_zero_reg <= (div_out_rem == '0);
        end
    end

    // Degree zero sits at zero octaves
    assign degree_value = r_rem_zero_reg ? '0 : ram_rdata_b;

    spmnb_tone u_tone (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (r_v_reg),
        .in_ready   (tone_in_ready),
        .in_quot    (r_quot_reg),
        .in_period  (ram_rdata_a),
        .in_degree  (degree_value),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (tone_status),
        .out_note   (tone_note),
        .out_bend   (tone_bend)
    );

    assign m_tuser = tone_status;
    assign m_tdata = {(OUT_DATA_W-NOTE_W-BEND_W)'(0), tone_bend, tone_note};

    // The clamped scale size stays in range in the input stage
    a_size_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        s0_v_reg |-> (s0_size_reg != '0 && s0_size_reg <= SIZE_W'(MAX_DEGREES)))
        else $error("scale size out of range in pipeline");

    // Only load requests write the table
    a_write_is_load: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !div_out_side.conv)
        else $error("table write from a convert request");

endmodule

/* test/tb_scale_pitch_to_midi_note_bend_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scale pitch to MIDI note and bend unit testbench
// Loads tuning tables, converts scale steps and checks every note, bend and
// status against an in-bench predictor. Runs several scale sizes, including
// the bad ones, with random gaps and back-pressure on both streams.
// ----------------------------------------------------------------------------
module tb_scale_pitch_to_midi_note_bend_unit;

    import spmnb_pkg::*;

    localparam int  CLK_HALF_NS = 5;
    localparam int  RESET_CYCLES = 9;
    localparam int  SETTLE_CYCLES = 32;
    localparam longint RUN_LIMIT_NS = 64'd10_000_000;

    typedef struct packed {
        logic        status;
        logic [6:0]  note;
        logic [11:0] bend;
    } note_bend_t;

    // ------------------------------------------------------------------------
    // Tuning predictor and store of expected notes
    // ------------------------------------------------------------------------
    class note_bend_scoreboard;
        logic [19:0] degree_pos [0:64];
        logic [6:0]  scale_size;
        note_bend_t  expected_notes [$];
        int unsigned errors;
        int unsigned conv_cnt;
        int unsigned load_cnt;
        int unsigned ignored_cnt;
        int unsigned out_of_range_cnt;
        int unsigned checked_cnt;

        function new();
            foreach (degree_pos[i])
                degree_pos[i] = '0;
            scale_size       = SCALE_SIZE_RESET;
            errors           = 0;
            conv_cnt         = 0;
            load_cnt         = 0;
            ignored_cnt      = 0;
            out_of_range_cnt = 0;
            checked_cnt      = 0;
        endfunction

        task report_mismatch(input string what);
            $display("[%0t] MISMATCH: %0s", $time, what);
            errors++;
        endtask

        function void set_scale_size(input logic [6:0] value);
            scale_size = value;
        endfunction

        function int unsigned pending();
            return expected_notes.size();
        endfunction

        // Note an accepted request: write the table or predict the note
        function void accept_request(input logic mode, input logic [15:0] pitch,
                                     input logic [6:0] didx, input logic [19:0] doct);
            int unsigned       eff;
            longint unsigned   periods, degree, octs, semis, note;
            longint            rem, bend;
            note_bend_t        res;
            if (mode == MODE_LOAD) begin
                if (didx >= 1 && didx <= MAX_DEGREES) begin
                    degree_pos[didx] = doct;
                    load_cnt++;
                end
                else
                    ignored_cnt++;
                return;
            end
            eff = scale_size;
            if (eff == 0)
                eff = 1;
            if (eff > MAX_DEGREES)
                eff = MAX_DEGREES;
            periods = pitch / eff;
            degree  = pitch % eff;
            octs    = periods * degree_pos[eff] + degree_pos[degree];
            semis   = octs * 12;
            note    = (semis + 64'h8000) >> 16;
            if (note >= NOTE_COUNT) begin
                res = '{status: 1'b1, note: '0, bend: '0};
                out_of_range_cnt++;
            end
            else begin
                rem  = longint'(semis) - longint'(note << 16);
                bend = rem / 16;
                res  = '{status: 1'b0, note: note[6:0], bend: bend[11:0]};
            end
            conv_cnt++;
            expected_notes.push_back(res);
        endfunction

        // Compare one result with the oldest prediction
        task check_note(input logic status, input logic [6:0] note,
                        input logic [11:0] bend);
            note_bend_t want;
            if (expected_notes.size() == 0) begin
                report_mismatch($sformatf("unexpected result status=%0b note=%0d bend=%0d",
                                          status, note, $signed(bend)));
                return;
            end
            want = expected_notes.pop_front();
            checked_cnt++;
            if (status !== want.status)
                report_mismatch($sformatf("status %0b, want %0b", status, want.status));
            if (note !== want.note)
                report_mismatch($sformatf("midi_note %0d, want %0d", note, want.note));
            if (bend !== want.bend)
                report_mismatch($sformatf("bend %0d, want %0d",
                                          $signed(bend), $signed(want.bend)));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // [15:0] pitch_index, [22:16] degree_index, [42:23] degree_octaves
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    // [0] mode
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [6:0] midi_note, [18:7] bend
    logic [OUT_DATA_W-1:0]  m_tdata;
    // [0] status
    logic                   m_tuser;

    bit                     src_burst = 1'b0;
    bit                     snk_burst = 1'b0;
    int unsigned            snk_hold = 0;
    int unsigned            phase_cnt = 0;
    note_bend_scoreboard    sb = new();

    scale_pitch_to_midi_note_bend_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    // Stall the result stream: mostly short holds, a few long ones
    always @(posedge clk or negedge rst_n)
    begin
        int unsigned r;
        if (!rst_n) begin
            m_tready <= 1'b0;
            snk_hold <= 0;
        end
        else if (snk_hold != 0) begin
            m_tready <= 1'b0;
            snk_hold <= snk_hold - 1;
        end
        else begin
            r = $urandom_range(0, 99);
            if (!snk_burst && r < 18) begin
                m_tready <= 1'b0;
                snk_hold <= (r < 2) ? $urandom_range(10, 40) : $urandom_range(0, 3);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Check every result taken from the block
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_note(m_tuser, m_tdata[6:0], m_tdata[18:7]);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (src_burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    task automatic send_request(input logic mode, input logic [15:0] pitch,
                                input logic [6:0] didx, input logic [19:0] doct);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {5'b0, doct, didx, pitch};
        do @(posedge clk); while (!s_tready);
        sb.accept_request(mode, pitch, didx, doct);
    endtask

    task automatic convert(input logic [15:0] pitch);
        send_request(MODE_CONVERT, pitch, 7'($urandom), 20'($urandom));
    endtask

    task automatic load_degree(input logic [6:0] didx, input logic [19:0] doct);
        send_request(MODE_LOAD, 16'($urandom), didx, doct);
    endtask

    // Hold off the request stream until every result has come back
    task automatic drain(input int unsigned extra);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic apb_access(input logic write, input logic [PADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write scale_size and read it back
    task automatic program_scale_size(input logic [6:0] value);
        logic [31:0] rd;
        apb_access(1'b1, {REG_SCALE_SIZE, 2'b00}, {25'b0, value}, rd);
        sb.set_scale_size(value);
        @(posedge clk);
        apb_access(1'b0, {REG_SCALE_SIZE, 2'b00}, '0, rd);
        if (rd !== {25'b0, value})
            sb.report_mismatch($sformatf("scale_size read %0h, want %0h", rd, value));
    endtask

    // ------------------------------------------------------------------------
    // Random phase: load a tuning, then mostly converts mixed with loads
    // ------------------------------------------------------------------------
    task automatic run_phase(input logic [6:0] size_val, input bit noisy,
                             input int unsigned n_items);
        int unsigned eff, period, span, r;
        logic [6:0]  idx;
        logic [19:0] val;
        drain(SETTLE_CYCLES);
        program_scale_size(size_val);
        phase_cnt++;
        eff = (size_val == 0) ? 1 : (size_val > MAX_DEGREES) ? MAX_DEGREES : size_val;
        period = $urandom_range(20'h06000, 20'h20000);
        span = eff * (655360 / period) + eff;
        if (span > 65535)
            span = 65535;

        // Fill every entry this size reads
        for (int k = 1; k <= eff; k++) begin
            if (noisy)
                val = 20'($urandom);
            else
                val = 20'((period * k) / eff + $urandom_range(0, 1023));
            load_degree(7'(k), val);
        end

        for (int n = 0; n < n_items; n++) begin
            if (n % 50 == 0) begin
                src_burst = ($urandom_range(0, 3) == 0);
                snk_burst = ($urandom_range(0, 3) == 0);
            end
            if (n == n_items / 2)
                drain(0);
            r = $urandom_range(0, 99);
            if (r < 80) begin
                if ($urandom_range(0, 99) < 85)
                    convert(16'($urandom_range(0, span)));
                else
                    convert(16'($urandom));
            end
            else if (r < 97) begin
                idx = 7'($urandom_range(1, MAX_DEGREES));
                if (!noisy && idx <= eff && $urandom_range(0, 3) != 0)
                    val = 20'((period * idx) / eff + $urandom_range(0, 1023));
                else
                    val = 20'($urandom);
                load_degree(idx, val);
            end
            else begin
                // Out-of-range load index, dropped by the block
                idx = ($urandom_range(0, 1) == 0) ? 7'd0 : 7'($urandom_range(65, 127));
                load_degree(idx, 20'($urandom));
            end
        end
        src_burst = 1'b0;
        snk_burst = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Twelve-tone equal temperament at the reset scale size
        for (int k = 1; k <= 12; k++)
            load_degree(7'(k), 20'((65536 * k) / 12));
        load_degree(7'd0, 20'hFFFFF);
        load_degree(7'd65, 20'h12345);
        load_degree(7'd127, 20'hABCDE);
        convert(16'd0);
        convert(16'd11);
        convert(16'd12);
        convert(16'd60);
        convert(16'hFFFF);
        // Exact half semitone rounds up
        load_degree(7'd1, 20'h02000);
        convert(16'd1);
        // Small negative remainder truncates to a zero bend
        load_degree(7'd1, 20'h0FFFF);
        convert(16'd1);
        // Top note with the largest bend
        load_degree(7'd1, 20'd696319);
        convert(16'd1);
        // First note past the range
        load_degree(7'd1, 20'd699051);
        convert(16'd1);
        // Largest degree position
        load_degree(7'd1, 20'hFFFFF);
        convert(16'd1);

        // Scale sizes: legal extremes, bad values, then ordinary ones
        run_phase(7'd1,   1'b0, 190);
        run_phase(7'd64,  1'b0, 130);
        run_phase(7'd0,   1'b0, 190);
        run_phase(7'd127, 1'b0, 130);
        run_phase(7'd12,  1'b0, 190);
        run_phase(7'd7,   1'b0, 190);
        run_phase(7'd53,  1'b1, 140);
        run_phase(7'($urandom_range(2, 63)), 1'b0, 190);

        drain(SETTLE_CYCLES);
        $display("Covered %0d scale sizes: %0d conversions (%0d past the note range), %0d loads",
                 phase_cnt + 1, sb.conv_cnt, sb.out_of_range_cnt, sb.load_cnt);
        $display("Dropped %0d loads with a bad index, checked %0d results",
                 sb.ignored_cnt, sb.checked_cnt);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #RUN_LIMIT_NS;
        $display("Run timed out with %0d results outstanding", sb.pending());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
